[hw/rtl/ycr_pkg.sv]
`timescale 1ns / 1ps

package ycr_pkg;

   localparam int FRAC_BITS_DEFAULT = 16;
   localparam int CHAN_W = 8;

   typedef struct packed {
      logic [CHAN_W-1:0] luma;
      logic [CHAN_W-1:0] chroma_blue;
      logic [CHAN_W-1:0] chroma_red;
   } ycr_pixel_in_type;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
   } ycr_pixel_out_type;

endpackage

[hw/rtl/ycr_channel_clamp.sv]
`timescale 1ns / 1ps

module ycr_channel_clamp #(
   parameter int FracBits = ycr_pkg::FRAC_BITS_DEFAULT,
   parameter int SumW     = FracBits + 12
) (
   input  logic signed [SumW-1:0]          sum,
   output logic [ycr_pkg::CHAN_W-1:0]      chan
);

   localparam logic [63:0] TopVal64 = 64'd255 << FracBits;
   localparam logic signed [SumW-1:0] TopVal = SumW'(TopVal64);

   always_comb begin
      priority if (sum[SumW-1]) begin
         chan = '0;
      end else if (sum >= TopVal) begin
         chan = '1;
      end else begin
         // floor: drop the fraction
         chan = sum[FracBits +: ycr_pkg::CHAN_W];
      end
   end

endmodule

[hw/rtl/ycbcr_to_rgb_converter_top.sv]
`timescale 1ns / 1ps
// A pixel passes from start to rsp_valid through the offset, multiply, sum and clamp stages.
// Throughput: one pixel per clock; busy stays low since the receiver cannot stall.
// Each result is shown for exactly one cycle under rsp_valid.
// Reset (synchronous, active high) clears the stage valid bits; items in flight are dropped.

module ycbcr_to_rgb_converter_top #(
   parameter int FracBits = ycr_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  ycr_pkg::ycr_pixel_in_type  req_pixel,
   output logic                       rsp_valid,
   output ycr_pkg::ycr_pixel_out_type rsp_pixel
);

   localparam int SumW = FracBits + 12;
   localparam int SampW = ycr_pkg::CHAN_W + 1;

   // unsigned coefficients, round to nearest with ties up
   localparam logic [63:0] Gain64 = ((64'd255 << FracBits) + 64'd219 / 2) / 64'd219;
   localparam logic [63:0] RedCr64 =
      ((64'd357510 << FracBits) + 64'd224000 / 2) / 64'd224000;
   localparam logic [63:0] BlueCb64 =
      ((64'd451860 << FracBits) + 64'd224000 / 2) / 64'd224000;
   localparam logic [63:0] GreenCb64 =
      ((64'd51512040 << FracBits) + 64'd131488000 / 2) / 64'd131488000;
   localparam logic [63:0] GreenCr64 =
      ((64'd106895490 << FracBits) + 64'd131488000 / 2) / 64'd131488000;

   localparam logic signed [SumW-1:0] GainS    = SumW'(Gain64);
   localparam logic signed [SumW-1:0] RedCrS   = SumW'(RedCr64);
   localparam logic signed [SumW-1:0] BlueCbS  = SumW'(BlueCb64);
   localparam logic signed [SumW-1:0] GreenCbS = SumW'(GreenCb64);
   localparam logic signed [SumW-1:0] GreenCrS = SumW'(GreenCr64);

   localparam logic signed [SampW-1:0] LumaOfs   = SampW'(16);
   localparam logic signed [SampW-1:0] ChromaOfs = SampW'(128);

   logic [3:0] valid_ff, valid_in;

   logic signed [SampW-1:0] y_ff, y_in, cb_ff, cb_in, cr_ff, cr_in;
   logic signed [SumW-1:0]  base_ff, base_in, rcr_ff, rcr_in, bcb_ff, bcb_in;
   logic signed [SumW-1:0]  gcb_ff, gcb_in, gcr_ff, gcr_in;
   logic signed [SumW-1:0]  red_sum_ff, red_sum_in, green_sum_ff, green_sum_in;
   logic signed [SumW-1:0]  blue_sum_ff, blue_sum_in;
   ycr_pkg::ycr_pixel_out_type pix_ff, pix_in;

   assign busy = 1'b0;

   assign valid_in = {valid_ff[2:0], start & ~busy};

   // stage 1: remove offsets
   assign y_in  = $signed({1'b0, req_pixel.luma}) - LumaOfs;
   assign cb_in = $signed({1'b0, req_pixel.chroma_blue}) - ChromaOfs;
   assign cr_in = $signed({1'b0, req_pixel.chroma_red}) - ChromaOfs;

   // stage 2: products
   assign base_in = GainS * SumW'(y_ff);
   assign rcr_in  = RedCrS * SumW'(cr_ff);
   assign bcb_in  = BlueCbS * SumW'(cb_ff);
   assign gcb_in  = GreenCbS * SumW'(cb_ff);
   assign gcr_in  = GreenCrS * SumW'(cr_ff);

   // stage 3: channel sums
   assign red_sum_in   = base_ff + rcr_ff;
   assign green_sum_in = base_ff - gcb_ff - gcr_ff;
   assign blue_sum_in  = base_ff + bcb_ff;

   // stage 4: clamp and truncate
   ycr_channel_clamp #(.FracBits(FracBits), .SumW(SumW)) u_clamp_red (
      .sum  (red_sum_ff),
      .chan (pix_in.red)
   );

   ycr_channel_clamp #(.FracBits(FracBits), .SumW(SumW)) u_clamp_green (
      .sum  (green_sum_ff),
      .chan (pix_in.green)
   );

   ycr_channel_clamp #(.FracBits(FracBits), .SumW(SumW)) u_clamp_blue (
      .sum  (blue_sum_ff),
      .chan (pix_in.blue)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      y_ff         <= y_in;
      cb_ff        <= cb_in;
      cr_ff        <= cr_in;
      base_ff      <= base_in;
      rcr_ff       <= rcr_in;
      bcb_ff       <= bcb_in;
      gcb_ff       <= gcb_in;
      gcr_ff       <= gcr_in;
      red_sum_ff   <= red_sum_in;
      green_sum_ff <= green_sum_in;
      blue_sum_ff  <= blue_sum_in;
      pix_ff       <= pix_in;
   end

   assign rsp_valid = valid_ff[3];
   assign rsp_pixel = pix_ff;

`ifndef SYNTHESIS
   a_no_busy: assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("busy raised");

   a_valid_has_source: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start, 4))
      else $error("result without a transfer four cycles earlier");

   a_black: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && $past(req_pixel.luma, 4) == 8'd0 &&
       $past(req_pixel.chroma_blue, 4) == 8'd128 &&
       $past(req_pixel.chroma_red, 4) == 8'd128) |-> (rsp_pixel == '0))
      else $error("black pixel not clamped to zero");

   a_white: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && $past(req_pixel.luma, 4) == 8'd255 &&
       $past(req_pixel.chroma_blue, 4) == 8'd128 &&
       $past(req_pixel.chroma_red, 4) == 8'd128) |-> (rsp_pixel == '1))
      else $error("white pixel not clamped to full scale");
`endif

endmodule

[verif/testbench.sv]
`timescale 1ns / 1ps

module testbench;

   localparam int FRAC = ycr_pkg::FRAC_BITS_DEFAULT;
   localparam longint LUMA_BLACK = 16;
   localparam longint CHROMA_ZERO = 128;
   localparam int DRAIN_CYCLES = 12;

   // scale a ratio to fixed point, round to nearest with ties up
   function automatic longint scaled_ratio(longint num, longint den);
      return ((num <<< FRAC) + den / 2) / den;
   endfunction

   localparam longint GAIN_Y   = scaled_ratio(255, 219);
   localparam longint RED_CR   = scaled_ratio(255 * 1402, 224 * 1000);
   localparam longint BLUE_CB  = scaled_ratio(255 * 1772, 224 * 1000);
   localparam longint GREEN_CB = scaled_ratio(longint'(255) * 1772 * 114,
                                              longint'(224) * 1000 * 587);
   localparam longint GREEN_CR = scaled_ratio(longint'(255) * 1402 * 299,
                                              longint'(224) * 1000 * 587);

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   ycr_pkg::ycr_pixel_in_type req_pixel = '0;
   logic rsp_valid;
   ycr_pkg::ycr_pixel_out_type rsp_pixel;

   ycr_pkg::ycr_pixel_in_type pixel_queue[$];
   ycr_pkg::ycr_pixel_out_type expected_rgb[$];
   logic xfer_done = 1'b0;
   int sender_idle_pct = 0;
   int error_count = 0;
   int pixels_sent = 0;
   int pixels_checked = 0;
   int clamped_channels = 0;
   int directed_count;

   ycbcr_to_rgb_converter_top #(
      .FracBits(FRAC)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_pixel(req_pixel),
      .rsp_valid(rsp_valid),
      .rsp_pixel(rsp_pixel)
   );

   always #4 clock = ~clock;

   // clamp to 0..255, then drop the fraction
   function automatic logic [ycr_pkg::CHAN_W-1:0] saturate_channel(longint acc);
      if (acc < 0) return '0;
      if (acc >= (longint'(255) <<< FRAC)) return 8'd255;
      return ycr_pkg::CHAN_W'(acc >>> FRAC);
   endfunction

   function automatic ycr_pkg::ycr_pixel_out_type convert_pixel(
      ycr_pkg::ycr_pixel_in_type px);
      longint y_off, cb_off, cr_off, base;
      ycr_pkg::ycr_pixel_out_type rgb;
      y_off = px.luma;
      cb_off = px.chroma_blue;
      cr_off = px.chroma_red;
      y_off -= LUMA_BLACK;
      cb_off -= CHROMA_ZERO;
      cr_off -= CHROMA_ZERO;
      base = GAIN_Y * y_off;
      rgb.red = saturate_channel(base + RED_CR * cr_off);
      rgb.green = saturate_channel(base - GREEN_CB * cb_off - GREEN_CR * cr_off);
      rgb.blue = saturate_channel(base + BLUE_CB * cb_off);
      return rgb;
   endfunction

   task automatic check_channel(string name, logic [ycr_pkg::CHAN_W-1:0] exp_val,
                                logic [ycr_pkg::CHAN_W-1:0] act_val);
      if (act_val !== exp_val) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name,
                  exp_val, act_val);
         error_count++;
      end
      if (exp_val == 0 || exp_val == 255) clamped_channels++;
   endtask

   // driver: advance to the next pixel once the current one has transferred
   always @(negedge clock) begin
      if (!reset) begin
         if (!start || xfer_done) begin
            if (pixel_queue.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
               req_pixel <= pixel_queue.pop_front();
               start <= 1'b1;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // monitor: check results, then record the transfer of this edge
   always @(posedge clock) begin
      ycr_pkg::ycr_pixel_out_type exp_rgb;
      if (!reset) begin
         if (rsp_valid === 1'b1) begin
            if (expected_rgb.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual %h", $time,
                        rsp_pixel);
               error_count++;
            end else begin
               exp_rgb = expected_rgb.pop_front();
               check_channel("red", exp_rgb.red, rsp_pixel.red);
               check_channel("green", exp_rgb.green, rsp_pixel.green);
               check_channel("blue", exp_rgb.blue, rsp_pixel.blue);
               pixels_checked++;
            end
         end
         if (start && busy === 1'b0) begin
            expected_rgb.push_back(convert_pixel(req_pixel));
            pixels_sent++;
         end
      end
      xfer_done <= !reset && start && busy === 1'b0;
   end

   task automatic push_pixel(logic [7:0] y, logic [7:0] cb, logic [7:0] cr);
      ycr_pkg::ycr_pixel_in_type px;
      px.luma = y;
      px.chroma_blue = cb;
      px.chroma_red = cr;
      pixel_queue.push_back(px);
   endtask

   function automatic logic [7:0] pick_sample(int mode, logic [7:0] lo, logic [7:0] hi);
      logic [7:0] corners[12] = '{0, 1, 15, 16, 17, 127, 128, 129, 235, 240, 254, 255};
      case (mode)
         0: return 8'($urandom_range(hi, lo));
         1: return corners[$urandom_range(11)];
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   task automatic queue_random_pixels(int count);
      int mode;
      repeat (count) begin
         // mostly full range, some legal studio range, some near the clamp points
         mode = $urandom_range(9);
         if (mode < 2)
            push_pixel(pick_sample(0, 16, 235), pick_sample(0, 16, 240),
                       pick_sample(0, 16, 240));
         else if (mode < 4)
            push_pixel(pick_sample(1, 0, 0), pick_sample(1, 0, 0), pick_sample(1, 0, 0));
         else
            push_pixel(pick_sample(2, 0, 0), pick_sample(2, 0, 0), pick_sample(2, 0, 0));
      end
   endtask

   task automatic wait_drained();
      while (pixel_queue.size() != 0 || start || expected_rgb.size() != 0)
         @(negedge clock);
   endtask

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      sender_idle_pct = 18;
      // black, white and beyond the studio range
      push_pixel(8'd16, 8'd128, 8'd128);
      push_pixel(8'd235, 8'd128, 8'd128);
      push_pixel(8'd0, 8'd128, 8'd128);
      push_pixel(8'd255, 8'd128, 8'd128);
      push_pixel(8'd0, 8'd0, 8'd0);
      push_pixel(8'd255, 8'd255, 8'd255);
      push_pixel(8'd0, 8'd255, 8'd255);
      push_pixel(8'd255, 8'd0, 8'd0);
      // chroma extremes at mid luma
      push_pixel(8'd128, 8'd0, 8'd0);
      push_pixel(8'd128, 8'd255, 8'd255);
      push_pixel(8'd128, 8'd0, 8'd255);
      push_pixel(8'd128, 8'd255, 8'd0);
      push_pixel(8'd128, 8'd16, 8'd240);
      push_pixel(8'd128, 8'd240, 8'd16);
      // primaries and secondaries
      push_pixel(8'd81, 8'd90, 8'd240);
      push_pixel(8'd145, 8'd54, 8'd34);
      push_pixel(8'd41, 8'd240, 8'd110);
      push_pixel(8'd210, 8'd16, 8'd146);
      push_pixel(8'd170, 8'd166, 8'd16);
      push_pixel(8'd106, 8'd202, 8'd222);
      // just around the luma offset and the top clamp
      push_pixel(8'd17, 8'd129, 8'd129);
      push_pixel(8'd15, 8'd127, 8'd127);
      push_pixel(8'd236, 8'd128, 8'd128);
      push_pixel(8'd1, 8'd1, 8'd254);
      push_pixel(8'd254, 8'd254, 8'd1);
      directed_count = pixel_queue.size();
      queue_random_pixels(215);
      wait_drained();

      sender_idle_pct = 47;
      queue_random_pixels(215);
      wait_drained();

      sender_idle_pct = 0;
      queue_random_pixels(220);
      wait_drained();

      // keep running to catch stray results
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("Sent %0d pixels (%0d directed corner cases) at sender idle 18%%, 47%% and 0%%.",
               pixels_sent, directed_count);
      $display("Checked %0d results, %0d channels at the 0 or 255 clamp, %0d errors.",
               pixels_checked, clamped_channels, error_count);
      if (error_count == 0 && expected_rgb.size() == 0)
         $display("testbench OK");
      else
         $display("testbench NOT OK");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Timeout with %0d pixels pending and %0d results outstanding",
               pixel_queue.size(), expected_rgb.size());
      $display("testbench NOT OK");
      $finish;
   end

endmodule

[filelist.f]
hw/rtl/ycr_pkg.sv
hw/rtl/ycr_channel_clamp.sv
hw/rtl/ycbcr_to_rgb_converter_top.sv
verif/testbench.sv
